>>> rtl/core/tsf_pkg.sv
// Shared types, register indexes, status codes and reset values of the touch sample filter.
package tsf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_RECIP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RECIP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_X_EXTENT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_Y_EXTENT = 3'd7;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_LOW = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  // Register values after reset.
  localparam logic [11:0] RST_MIN_VALID = 12'd100;
  localparam logic [11:0] RST_MATCH_RANGE = 12'd50;
  localparam logic [11:0] RST_X_OFFSET = 12'd129;
  localparam logic [11:0] RST_Y_OFFSET = 12'd286;
  localparam logic [15:0] RST_X_RECIP = 16'd8792;
  localparam logic [15:0] RST_Y_RECIP = 16'd12868;
  localparam logic [9:0] RST_X_EXTENT = 10'd240;
  localparam logic [9:0] RST_Y_EXTENT = 10'd320;

  typedef struct packed {
    logic [11:0] min_valid;
    logic [11:0] match_range;
    logic [11:0] x_offset;
    logic [11:0] y_offset;
    logic [15:0] x_recip;
    logic [15:0] y_recip;
    logic [9:0] x_extent;
    logic [9:0] y_extent;
  } cfg_t;

  // One classified sample word as it travels from front to back.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic restart;
    logic first;
    logic last;
  } item_t;

endpackage

>>> rtl/core/tsf_front.sv
// Front end: accepts sample words, tracks the slot within a group and tags each word.
module tsf_front #(
  parameter int GROUP_SIZE = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tsf_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           restart_i,
  input  logic                           full_i,
  output logic                           busy_o,
  output logic                           push_o,
  output tsf_pkg::item_t                 item_o
);
  import tsf_pkg::*;

  localparam int IDX_W = $clog2(GROUP_SIZE);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(GROUP_SIZE - 1);

  logic [IDX_W-1:0] slot_q, slot_d;
  logic [IDX_W-1:0] cur_slot;
  logic             is_last;

  // A restart word always opens a new attempt at slot zero.
  assign cur_slot = restart_i ? '0 : slot_q;
  assign is_last = (cur_slot == LAST_SLOT);
  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  assign item_o.sample = sample_i;
  assign item_o.restart = restart_i;
  assign item_o.first = (cur_slot == '0);
  assign item_o.last = is_last;

  always_comb begin
    slot_d = slot_q;
    if (push_o) begin
      slot_d = is_last ? '0 : cur_slot + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

>>> rtl/core/tsf_fifo.sv
// Short queue of classified sample words between the front and back ends.
module tsf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tsf_pkg::item_t push_item_i,
  input  logic           pop_i,
  output tsf_pkg::item_t pop_item_o,
  output logic           full_o,
  output logic           empty_o
);
  import tsf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             do_push, do_pop;

  assign full_o = (count_q == DEPTH_CNT);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  // Storage words carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/tsf_back.sv
// Back end: stores a group, forms the trimmed mean, checks the reads and scales coordinates.
module tsf_back #(
  parameter int GROUP_SIZE    = 10,
  parameter int DROP_EACH_END = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsf_pkg::cfg_t        cfg_i,
  input  tsf_pkg::item_t       item_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [11:0]          x_adc_o,
  output logic [11:0]          y_adc_o,
  output logic signed [11:0]   x_coord_o,
  output logic signed [11:0]   y_coord_o
);
  import tsf_pkg::*;

  localparam int IDX_W = $clog2(GROUP_SIZE);
  localparam int DROP_EFF = (2 * DROP_EACH_END >= GROUP_SIZE) ? (GROUP_SIZE - 1) / 2
                                                              : DROP_EACH_END;
  localparam int KEEP = GROUP_SIZE - 2 * DROP_EFF;
  localparam int SUM_W = SAMPLE_W + $clog2(GROUP_SIZE);
  localparam int KEEP_L = $clog2(KEEP);
  localparam int SH = SUM_W + KEEP_L;
  localparam int MUL_W = SUM_W + 1;
  localparam longint unsigned RECIP_M = ((64'd1 << SH) + 64'(KEEP) - 64'd1) / 64'(KEEP);
  localparam logic [MUL_W-1:0] KEEP_RECIP = MUL_W'(RECIP_M);
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_SIZE - 1);
  localparam logic [IDX_W:0] RANK_LO = (IDX_W + 1)'(DROP_EFF);
  localparam logic [IDX_W:0] RANK_HI = (IDX_W + 1)'(GROUP_SIZE - DROP_EFF);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANK,
    S_MUL,
    S_DECIDE,
    S_XMUL,
    S_XSUB,
    S_YMUL,
    S_YSUB
  } state_e;

  state_e              state_q;
  logic [SAMPLE_W-1:0] store_q [GROUP_SIZE];
  logic [IDX_W-1:0]    wr_idx_q;
  logic [IDX_W-1:0]    rank_idx_q;
  logic [1:0]          phase_q;
  logic [SUM_W-1:0]    sum_q;
  logic [PROD_W-1:0]   prod_q;
  logic [11:0]         first_x_q, first_y_q, round_x_q;
  logic [11:0]         xa_q, ya_q;
  logic [27:0]         cprod_q;
  logic                neg_q;
  logic                done_q;
  logic [1:0]          status_q;
  logic [11:0]         x_adc_q, y_adc_q;
  logic [11:0]         x_coord_q, y_coord_q;

  logic [IDX_W-1:0]    wr_idx;
  logic [SAMPLE_W-1:0] cur;
  logic [GROUP_SIZE-1:0] below;
  logic [IDX_W:0]      rank;
  logic                keep_it;
  logic [11:0]         mean;
  logic                low_fail;
  logic [11:0]         dx, dy;
  logic                close_ok;
  logic [12:0]         xa_sum, ya_sum;
  logic [11:0]         m_adc, m_off;
  logic [15:0]         m_recip;
  logic [11:0]         m_diff;
  logic                m_neg;
  logic [11:0]         cq;
  logic [11:0]         c_ext;
  logic [11:0]         c_val;

  assign pop_o = (state_q == S_IDLE) && !empty_i;
  assign wr_idx = item_i.first ? '0 : wr_idx_q;

  // Stable rank of the entry under test: smaller values, or equal values stored earlier.
  assign cur = store_q[rank_idx_q];
  always_comb begin
    for (int j = 0; j < GROUP_SIZE; j++) begin
      below[j] = (store_q[j] < cur) || ((store_q[j] == cur) && (IDX_W'(j) < rank_idx_q));
    end
  end
  assign rank = (IDX_W + 1)'($countones(below));
  assign keep_it = (rank >= RANK_LO) && (rank < RANK_HI);

  // Mean of the kept values, and the checks on the finished reads.
  assign mean = prod_q[SH +: 12];
  assign low_fail = (round_x_q < cfg_i.min_valid) || (mean < cfg_i.min_valid);
  assign dx = (first_x_q >= round_x_q) ? first_x_q - round_x_q : round_x_q - first_x_q;
  assign dy = (first_y_q >= mean) ? first_y_q - mean : mean - first_y_q;
  assign close_ok = (dx < cfg_i.match_range) && (dy < cfg_i.match_range);
  assign xa_sum = {1'b0, first_x_q} + {1'b0, round_x_q};
  assign ya_sum = {1'b0, first_y_q} + {1'b0, mean};

  // Shared scaling multiplier operands, X first and then Y.
  assign m_adc = (state_q == S_XMUL) ? xa_q : ya_q;
  assign m_off = (state_q == S_XMUL) ? cfg_i.x_offset : cfg_i.y_offset;
  assign m_recip = (state_q == S_XMUL) ? cfg_i.x_recip : cfg_i.y_recip;
  assign m_neg = (m_adc < m_off);
  assign m_diff = m_neg ? m_off - m_adc : m_adc - m_off;

  // Coordinate is the extent minus the scaled value, wrapped to 12 bits.
  assign cq = cprod_q[27:16];
  assign c_ext = (state_q == S_XSUB) ? {2'b00, cfg_i.x_extent} : {2'b00, cfg_i.y_extent};
  assign c_val = neg_q ? c_ext + cq : c_ext - cq;

  // Sample store has no reset; each group writes every entry before it is ranked.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      store_q[wr_idx] <= item_i.sample;
    end
  end

  // Sequencer with the registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wr_idx_q <= '0;
      rank_idx_q <= '0;
      phase_q <= 2'd0;
      sum_q <= '0;
      prod_q <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      round_x_q <= '0;
      xa_q <= '0;
      ya_q <= '0;
      cprod_q <= '0;
      neg_q <= 1'b0;
      done_q <= 1'b0;
      status_q <= ST_OK;
      x_adc_q <= '0;
      y_adc_q <= '0;
      x_coord_q <= '0;
      y_coord_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            wr_idx_q <= wr_idx + 1'b1;
            if (item_i.restart) begin
              phase_q <= 2'd0;
            end
            if (item_i.last) begin
              rank_idx_q <= '0;
              sum_q <= '0;
              state_q <= S_RANK;
            end
          end
        end
        S_RANK: begin
          if (keep_it) begin
            sum_q <= sum_q + SUM_W'(cur);
          end
          if (rank_idx_q == LAST_IDX) begin
            state_q <= S_MUL;
          end else begin
            rank_idx_q <= rank_idx_q + 1'b1;
          end
        end
        S_MUL: begin
          prod_q <= PROD_W'(sum_q) * PROD_W'(KEEP_RECIP);
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          state_q <= S_IDLE;
          if (phase_q == 2'd0 || phase_q == 2'd2) begin
            round_x_q <= mean;
            phase_q <= phase_q + 2'd1;
          end else if (low_fail) begin
            phase_q <= 2'd0;
            done_q <= 1'b1;
            status_q <= ST_LOW;
            x_adc_q <= '0;
            y_adc_q <= '0;
            x_coord_q <= '0;
            y_coord_q <= '0;
          end else if (phase_q == 2'd1) begin
            first_x_q <= round_x_q;
            first_y_q <= mean;
            phase_q <= 2'd2;
          end else if (close_ok) begin
            phase_q <= 2'd0;
            xa_q <= xa_sum[12:1];
            ya_q <= ya_sum[12:1];
            state_q <= S_XMUL;
          end else begin
            phase_q <= 2'd0;
            done_q <= 1'b1;
            status_q <= ST_MISMATCH;
            x_adc_q <= '0;
            y_adc_q <= '0;
            x_coord_q <= '0;
            y_coord_q <= '0;
          end
        end
        S_XMUL, S_YMUL: begin
          cprod_q <= 28'(m_diff) * 28'(m_recip);
          neg_q <= m_neg;
          state_q <= (state_q == S_XMUL) ? S_XSUB : S_YSUB;
        end
        S_XSUB: begin
          x_coord_q <= c_val;
          state_q <= S_YMUL;
        end
        S_YSUB: begin
          y_coord_q <= c_val;
          x_adc_q <= xa_q;
          y_adc_q <= ya_q;
          status_q <= ST_OK;
          done_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign x_adc_o = x_adc_q;
  assign y_adc_o = y_adc_q;
  assign x_coord_o = x_coord_q;
  assign y_coord_o = y_coord_q;

endmodule

>>> rtl/core/touch_sample_filter.sv
// Top level of the touch sample filter: registers, front end, queue and back end.
//
//   channel   direction  handshake                     word
//   sample    in         start_i high, busy_o low      sample_i, restart_i
//   result    out        done_o high for one cycle     status_o, x_adc_o, y_adc_o,
//                                                      x_coord_o, y_coord_o
//   config    in         cfg_valid_i and cfg_ready_o   cfg_index_i, cfg_data_i
//
// A sample word is taken whenever the queue has room; busy_o is the queue's full
// flag. The back end pops an ordinary word while idle; on the last word of a group
// it goes through the pop, one rank per cycle, the mean multiply and the decision,
// and at the end of a matching attempt it scales the coordinates on the shared
// multiplier (X multiply, X subtract, Y multiply, Y subtract). After reset the filter
// starts at the first X sample.
// The result port cannot be stalled; each result is shown for exactly one cycle.
module touch_sample_filter #(
  parameter int GROUP_SIZE    = 10,
  parameter int DROP_EACH_END = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [11:0]                       sample_i,
  input  logic                              restart_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [11:0]                       x_adc_o,
  output logic [11:0]                       y_adc_o,
  output logic signed [11:0]                x_coord_o,
  output logic signed [11:0]                y_coord_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tsf_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, pop_item;
  logic  push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; each write keeps only the register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_valid <= RST_MIN_VALID;
      cfg_q.match_range <= RST_MATCH_RANGE;
      cfg_q.x_offset <= RST_X_OFFSET;
      cfg_q.y_offset <= RST_Y_OFFSET;
      cfg_q.x_recip <= RST_X_RECIP;
      cfg_q.y_recip <= RST_Y_RECIP;
      cfg_q.x_extent <= RST_X_EXTENT;
      cfg_q.y_extent <= RST_Y_EXTENT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MIN_VALID:   cfg_q.min_valid <= cfg_data_i[11:0];
        REG_MATCH_RANGE: cfg_q.match_range <= cfg_data_i[11:0];
        REG_X_OFFSET:    cfg_q.x_offset <= cfg_data_i[11:0];
        REG_Y_OFFSET:    cfg_q.y_offset <= cfg_data_i[11:0];
        REG_X_RECIP:     cfg_q.x_recip <= cfg_data_i;
        REG_Y_RECIP:     cfg_q.y_recip <= cfg_data_i;
        REG_X_EXTENT:    cfg_q.x_extent <= cfg_data_i[9:0];
        REG_Y_EXTENT:    cfg_q.y_extent <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  tsf_front #(
    .GROUP_SIZE(GROUP_SIZE)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .sample_i (sample_i),
    .restart_i(restart_i),
    .full_i   (full),
    .busy_o   (busy_o),
    .push_o   (push),
    .item_o   (push_item)
  );

  tsf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .pop_item_o (pop_item),
    .full_o     (full),
    .empty_o    (empty)
  );

  tsf_back #(
    .GROUP_SIZE   (GROUP_SIZE),
    .DROP_EACH_END(DROP_EACH_END)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (pop_item),
    .empty_i  (empty),
    .pop_o    (pop),
    .done_o   (done_o),
    .status_o (status_o),
    .x_adc_o  (x_adc_o),
    .y_adc_o  (y_adc_o),
    .x_coord_o(x_coord_o),
    .y_coord_o(y_coord_o)
  );

  // Results are at least a group of samples apart; the check is only that done_o is never high twice in a row.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // A failed attempt reports all data fields as zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |->
      (x_adc_o == '0 && y_adc_o == '0 && x_coord_o == '0 && y_coord_o == '0))
    else $error("failed result carries nonzero data");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_LOW || status_o == ST_MISMATCH))
    else $error("undefined status code");

  // The queue never takes a word while full.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("sample word pushed into a full queue");

endmodule

>>> dv/touch_sample_filter_test.sv
// Self-checking testbench for the touch sample filter with its own trimmed-mean predictor.
`timescale 1ns / 100ps

module touch_sample_filter_test;
  import tsf_pkg::*;

  localparam int GROUP = 10;
  localparam int DROP = 4;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;

  // One filtered position report as it leaves the block.
  typedef struct packed {
    logic [1:0] status;
    logic [11:0] x_adc;
    logic [11:0] y_adc;
    logic [11:0] x_coord;
    logic [11:0] y_coord;
  } touch_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [11:0] sample_i;
  logic restart_i;
  logic done_o;
  logic [1:0] status_o;
  logic [11:0] x_adc_o;
  logic [11:0] y_adc_o;
  logic signed [11:0] x_coord_o;
  logic signed [11:0] y_coord_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Predictor state: register copy, sample group and attempt progress.
  cfg_t filt_cfg;
  logic [11:0] held_samples [GROUP];
  int unsigned attempt_pos;
  logic [11:0] first_x_mean;
  logic [11:0] first_y_mean;
  logic [11:0] cur_x_mean;

  touch_report_t pending_reports [$];
  touch_report_t seen_report;
  touch_report_t want_report;
  int unsigned mismatches;
  int unsigned samples_sent;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;

  touch_sample_filter #(
    .GROUP_SIZE   (GROUP),
    .DROP_EACH_END(DROP)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .sample_i   (sample_i),
    .restart_i  (restart_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .x_adc_o    (x_adc_o),
    .y_adc_o    (y_adc_o),
    .x_coord_o  (x_coord_o),
    .y_coord_o  (y_coord_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("touch_sample_filter: mismatch");
      $finish;
    end
  end

  // Sort the current group, drop the extremes and take the floor mean of the rest.
  function automatic logic [11:0] trimmed_mean();
    int unsigned vals [GROUP];
    int unsigned tmp;
    int unsigned total;
    int unsigned drop;
    int i;
    int j;
    for (i = 0; i < GROUP; i++) vals[i] = held_samples[i];
    for (i = 1; i < GROUP; i++) begin
      tmp = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > tmp) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = tmp;
    end
    drop = DROP;
    if (2 * drop >= GROUP) drop = (GROUP - 1) / 2;
    total = 0;
    for (i = drop; i < GROUP - drop; i++) total += vals[i];
    return 12'(total / (GROUP - 2 * drop));
  endfunction

  // Screen coordinate: extent minus the scaled offset distance, truncated toward zero.
  function automatic logic [11:0] screen_coord(input logic [11:0] adc, input logic [11:0] off,
                                               input logic [15:0] recip,
                                               input logic [9:0] extent);
    int unsigned span;
    int unsigned mag;
    int scaled;
    span = (adc >= off) ? int'(adc) - int'(off) : int'(off) - int'(adc);
    mag = (span * int'(recip)) >> 16;
    scaled = (adc >= off) ? int'(mag) : -int'(mag);
    return 12'(int'(extent) - scaled);
  endfunction

  function automatic bit reads_agree(input logic [11:0] a, input logic [11:0] b);
    int unsigned diff;
    diff = (a >= b) ? a - b : b - a;
    return diff < filt_cfg.match_range;
  endfunction

  // Advance the predictor by one accepted sample word and queue any report it ends.
  function automatic void predict_sample(input logic [11:0] s, input logic r);
    int unsigned phase;
    int unsigned slot;
    logic [11:0] grp_mean;
    touch_report_t rep;
    if (r || attempt_pos >= 4 * GROUP) attempt_pos = 0;
    phase = attempt_pos / GROUP;
    slot = attempt_pos % GROUP;
    held_samples[slot] = s;
    attempt_pos++;
    if (slot != GROUP - 1) return;
    grp_mean = trimmed_mean();
    if (phase == 0 || phase == 2) begin
      cur_x_mean = grp_mean;
      return;
    end
    rep = '0;
    if (cur_x_mean < filt_cfg.min_valid || grp_mean < filt_cfg.min_valid) begin
      rep.status = ST_LOW;
      attempt_pos = 0;
      pending_reports.push_back(rep);
      return;
    end
    if (phase == 1) begin
      first_x_mean = cur_x_mean;
      first_y_mean = grp_mean;
      return;
    end
    attempt_pos = 0;
    if (reads_agree(first_x_mean, cur_x_mean) && reads_agree(first_y_mean, grp_mean)) begin
      rep.status = ST_OK;
      rep.x_adc = 12'((int'(first_x_mean) + int'(cur_x_mean)) >> 1);
      rep.y_adc = 12'((int'(first_y_mean) + int'(grp_mean)) >> 1);
      rep.x_coord = screen_coord(rep.x_adc, filt_cfg.x_offset, filt_cfg.x_recip,
                                 filt_cfg.x_extent);
      rep.y_coord = screen_coord(rep.y_adc, filt_cfg.y_offset, filt_cfg.y_recip,
                                 filt_cfg.y_extent);
    end else begin
      rep.status = ST_MISMATCH;
    end
    pending_reports.push_back(rep);
  endfunction

  function automatic logic [11:0] clip12(input int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return 12'(v);
  endfunction

  // Compare every report on the result port with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      seen_report.status = status_o;
      seen_report.x_adc = x_adc_o;
      seen_report.y_adc = y_adc_o;
      seen_report.x_coord = x_coord_o;
      seen_report.y_coord = y_coord_o;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with none expected: status %0d x_adc %0d y_adc %0d",
                   $realtime, status_o, x_adc_o, y_adc_o);
      end else begin
        want_report = pending_reports.pop_front();
        if (want_report.status != seen_report.status ||
            want_report.x_adc != seen_report.x_adc ||
            want_report.y_adc != seen_report.y_adc ||
            want_report.x_coord != seen_report.x_coord ||
            want_report.y_coord != seen_report.y_coord) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected st %0d adc %0d/%0d xy %0d/%0d, got st %0d adc %0d/%0d xy %0d/%0d",
                     $realtime, want_report.status, want_report.x_adc, want_report.y_adc,
                     $signed(want_report.x_coord), $signed(want_report.y_coord),
                     status_o, x_adc_o, y_adc_o, x_coord_o, y_coord_o);
        end
      end
    end
  end

  // Offer one sample word, idling first at random, and predict it once taken.
  task automatic send_sample(input logic [11:0] s, input logic r);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    sample_i <= s;
    restart_i <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_sample(s, r);
    samples_sent++;
  endtask

  // Write one register; valid stays high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_MIN_VALID: filt_cfg.min_valid = data[11:0];
      REG_MATCH_RANGE: filt_cfg.match_range = data[11:0];
      REG_X_OFFSET: filt_cfg.x_offset = data[11:0];
      REG_Y_OFFSET: filt_cfg.y_offset = data[11:0];
      REG_X_RECIP: filt_cfg.x_recip = data;
      REG_Y_RECIP: filt_cfg.y_recip = data;
      REG_X_EXTENT: filt_cfg.x_extent = data[9:0];
      REG_Y_EXTENT: filt_cfg.y_extent = data[9:0];
      default: ;
    endcase
  endtask

  // Load a full register set; unused upper data bits carry random junk.
  task automatic load_config(input cfg_t c);
    write_reg(REG_MIN_VALID, {4'($urandom), c.min_valid});
    write_reg(REG_MATCH_RANGE, {4'($urandom), c.match_range});
    write_reg(REG_X_OFFSET, {4'($urandom), c.x_offset});
    write_reg(REG_Y_OFFSET, {4'($urandom), c.y_offset});
    write_reg(REG_X_RECIP, c.x_recip);
    write_reg(REG_Y_RECIP, c.y_recip);
    write_reg(REG_X_EXTENT, {6'($urandom), c.x_extent});
    write_reg(REG_Y_EXTENT, {6'($urandom), c.y_extent});
    cfg_valid_i <= 1'b0;
  endtask

  // Let all predicted reports arrive, then give the back end time to drain.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Ten samples around a base value with the odd full-range outlier.
  task automatic send_group(input int base, input int spread, input bit lead_restart);
    logic [11:0] s;
    int i;
    for (i = 0; i < GROUP; i++) begin
      if ($urandom_range(9) == 0) s = 12'($urandom);
      else s = clip12(base + int'($urandom_range(2 * spread)) - spread);
      send_sample(s, lead_restart && i == 0);
    end
  endtask

  // One attempt: mostly well-formed with random content, some low, disagreeing or noise.
  task automatic run_attempt();
    int unsigned kind;
    int unsigned n;
    int lo;
    int spread;
    int shift;
    int g;
    int bases [4];
    bit lead_restart;
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(15, 1);
      repeat (n) send_sample(12'($urandom), $urandom_range(3) == 0);
      return;
    end
    lo = int'(filt_cfg.min_valid);
    spread = int'(filt_cfg.match_range) / 6;
    if (spread > 40) spread = 40;
    bases[0] = $urandom_range(4095, lo);
    bases[1] = $urandom_range(4095, lo);
    bases[2] = clip12(bases[0] + int'($urandom_range(2 * spread)) - spread);
    bases[3] = clip12(bases[1] + int'($urandom_range(2 * spread)) - spread);
    if (kind < 25 && lo > 0) begin
      bases[$urandom_range(3)] = $urandom_range(lo - 1, 0);
    end else if (kind < 40) begin
      shift = int'(filt_cfg.match_range) + int'($urandom_range(200));
      if ($urandom_range(1) == 1) shift = -shift;
      g = $urandom_range(3, 2);
      bases[g] = clip12(bases[g] + shift);
    end
    lead_restart = (attempt_pos != 0) || ($urandom_range(1) == 1);
    for (g = 0; g < 4; g++) begin
      // A low first read closes the attempt early.
      if (g == 2 && attempt_pos == 0) break;
      send_group(bases[g], spread, lead_restart && g == 0);
    end
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned first;
    first = samples_sent;
    while (samples_sent - first < count) run_attempt();
    wait_idle();
  endtask

  // Stray partial samples, then a restart into a first read that is below the minimum.
  task automatic test_directed();
    logic [11:0] x_vals [GROUP];
    logic [11:0] y_vals [GROUP];
    int i;
    x_vals = '{12'd0, 12'd4095, 12'd40, 12'd45, 12'd50, 12'd55, 12'd60, 12'd65,
               12'd4095, 12'd0};
    y_vals = '{12'h555, 12'hAAA, 12'h800, 12'h7FF, 12'h001, 12'hFFE, 12'h400, 12'h3FF,
               12'h200, 12'h100};
    sender_idle_pct = 25;
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'hA5A, 1'b0);
    for (i = 0; i < GROUP; i++) send_sample(x_vals[i], i == 0);
    for (i = 0; i < GROUP; i++) send_sample(y_vals[i], 1'b0);
    wait_idle();
  endtask

  task automatic test_default_config();
    sender_idle_pct = 25;
    run_phase(600);
  endtask

  // No minimum, widest match window, full-scale scaling: coordinates wrap both ways.
  task automatic test_extreme_config();
    cfg_t c;
    c.min_valid = 12'd0;
    c.match_range = 12'd4095;
    c.x_offset = 12'd4095;
    c.y_offset = 12'd0;
    c.x_recip = 16'hFFFF;
    c.y_recip = 16'hFFFF;
    c.x_extent = 10'd0;
    c.y_extent = 10'd1023;
    sender_idle_pct = 65;
    load_config(c);
    run_phase(600);
  endtask

  // Highest minimum and a zero match window: every attempt that ends in a report fails.
  task automatic test_zero_range_config();
    cfg_t c;
    c.min_valid = 12'd4095;
    c.match_range = 12'd0;
    c.x_offset = 12'd0;
    c.y_offset = 12'd4095;
    c.x_recip = 16'd0;
    c.y_recip = 16'd0;
    c.x_extent = 10'd1023;
    c.y_extent = 10'd0;
    sender_idle_pct = 0;
    load_config(c);
    run_phase(150);
  endtask

  task automatic test_random_config();
    cfg_t c;
    c.min_valid = 12'($urandom_range(300));
    c.match_range = 12'($urandom_range(300, 20));
    c.x_offset = 12'($urandom);
    c.y_offset = 12'($urandom);
    c.x_recip = 16'($urandom);
    c.y_recip = 16'($urandom);
    c.x_extent = 10'($urandom);
    c.y_extent = 10'($urandom);
    sender_idle_pct = 0;
    load_config(c);
    run_phase(600);
  endtask

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    sample_i <= '0;
    restart_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    mismatches = 0;
    samples_sent = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    filt_cfg.min_valid = RST_MIN_VALID;
    filt_cfg.match_range = RST_MATCH_RANGE;
    filt_cfg.x_offset = RST_X_OFFSET;
    filt_cfg.y_offset = RST_Y_OFFSET;
    filt_cfg.x_recip = RST_X_RECIP;
    filt_cfg.y_recip = RST_Y_RECIP;
    filt_cfg.x_extent = RST_X_EXTENT;
    filt_cfg.y_extent = RST_Y_EXTENT;
    attempt_pos = 0;
    first_x_mean = '0;
    first_y_mean = '0;
    cur_x_mean = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_default_config();
    test_extreme_config();
    test_zero_range_config();
    test_random_config();

    if (mismatches == 0) begin
      $display("touch_sample_filter: match");
    end else begin
      $display("touch_sample_filter: mismatch");
    end
    $finish;
  end

endmodule
